[rtl/tolr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tolr_pkg
// Shared types, constants and helpers for the third-order limited
// reconstruction block.
// ----------------------------------------------------------------------------
package tolr_pkg;

    localparam int WORD_W     = 32;
    localparam int WIDTH_W    = 31;
    localparam int SQ_W       = 62;
    localparam int SUM_W      = 48;
    localparam int LIM_W      = 40;
    localparam int DIV_W      = 40;
    localparam int BLEND_BITS = 16;
    localparam int CNT_W      = 4;
    localparam int EPS_SHIFT  = 12;

    // largest sum of squares whose scaled value still fits 64 bits
    localparam logic [63:0] S_LIMIT = 64'd184467440737095516;
    // 1e12 = 244140625 * 2^12
    localparam logic [27:0] EPS_ODD = 28'd244140625;

    localparam logic [CNT_W-1:0] BLEND_LAST = CNT_W'(BLEND_BITS - 1);
    localparam logic [CNT_W-1:0] DIV_LAST   = CNT_W'(DIV_W / 8 - 1);

    typedef struct packed {
        logic signed [WORD_W-1:0] sample_value;
        logic [WIDTH_W-1:0]       cell_width;
        logic                     row_start;
    } in_item_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] right_face_value;
        logic signed [WORD_W-1:0] left_face_value;
        logic                     fallback_used;
        logic                     saturated;
    } out_item_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] middle;
        logic signed [WORD_W-1:0] dp;
        logic signed [WORD_W-1:0] dm;
        logic [WIDTH_W-1:0]       dx;
        logic                     sat;
    } job_t;

    typedef struct packed {
        logic                    hit;
        logic signed [WORD_W-1:0] value;
    } clip_t;

    typedef struct packed {
        logic signed [LIM_W-1:0] q6;
        logic signed [LIM_W-1:0] psi6;
        logic                    neg;
        logic                    zero;
    } lim_t;

    typedef enum logic [1:0] {
        BAND_Q,
        BAND_PSI,
        BAND_BLEND
    } band_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SCALE,
        ST_BAND,
        ST_CLASS,
        ST_BLEND,
        ST_MIX,
        ST_L12,
        ST_DIV3,
        ST_FACE,
        ST_GUARD,
        ST_OUT
    } back_state_t;

    // saturate a wide signed value to the word range
    function automatic clip_t clip_word(input logic signed [SUM_W-1:0] x);
        clip_t r;
        r.hit = !((&x[SUM_W-1:WORD_W-1]) || !(|x[SUM_W-1:WORD_W-1]));
        if (r.hit) begin
            r.value = x[SUM_W-1] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
        end else begin
            r.value = x[WORD_W-1:0];
        end
        return r;
    endfunction

endpackage

[rtl/third_order_limited_reconstruction.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// third_order_limited_reconstruction
// Compact third-order limited reconstruction of one variable along a row,
// with optional minmod positivity fallback, Q16.16 fixed point.
//
//   channel   ports                  payload
//   input     s_valid / s_ready      s_data  (tolr_pkg::in_item_t)
//   result    m_valid / m_ready      m_data  (tolr_pkg::out_item_t)
//   config    cfg_we                 cfg_wdata (positivity enable)
//
// The window front takes one item per cycle while the two-entry queue has room.
// The back end works on one result at a time; a 16-bit restoring division for the
// blend weight is added when it is needed, and the divide by three is byte-serial.
// aresetn is synchronous, active low; it empties the window and the queue.
// A stalled result holds the back end; the front keeps filling the queue.
// ----------------------------------------------------------------------------
module third_order_limited_reconstruction (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tolr_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tolr_pkg::out_item_t m_data,
    input  logic                cfg_we,
    input  logic                cfg_wdata
);

    logic           pos_en_reg;
    tolr_pkg::job_t push_data;
    logic           push;
    logic           full;
    tolr_pkg::job_t pop_data;
    logic           pop_valid;
    logic           pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_en_reg <= 1'b0;
        end else if (cfg_we) begin
            pos_en_reg <= cfg_wdata;
        end
    end

    tolr_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .job_data (push_data),
        .job_push (push),
        .job_full (full)
    );

    tolr_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_data (push_data),
        .push      (push),
        .full      (full),
        .pop_data  (pop_data),
        .pop_valid (pop_valid),
        .pop       (pop)
    );

    tolr_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .positivity_enable (pos_en_reg),
        .job_data          (pop_data),
        .job_valid         (pop_valid),
        .job_pop           (pop),
        .m_data            (m_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready)
    );

endmodule

[rtl/tolr_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tolr_fifo
// Two-entry queue of prepared cells between the window front and the
// limiter back end.
// ----------------------------------------------------------------------------
module tolr_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  tolr_pkg::job_t  push_data,
    input  logic            push,
    output logic            full,
    output tolr_pkg::job_t  pop_data,
    output logic            pop_valid,
    input  logic            pop
);

    tolr_pkg::job_t slot_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/tolr_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tolr_front
// Three-sample window: takes items, forms both clipped differences of the
// middle cell and hands a job to the queue once the window is full.
// ----------------------------------------------------------------------------
module tolr_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tolr_pkg::in_item_t s_data,
    output tolr_pkg::job_t     job_data,
    output logic               job_push,
    input  logic               job_full
);

    logic [1:0]                         fill_reg;
    logic [1:0]                         fill_eff;
    logic signed [tolr_pkg::WORD_W-1:0] older_reg;
    logic signed [tolr_pkg::WORD_W-1:0] middle_reg;
    logic [tolr_pkg::WIDTH_W-1:0]       width_reg;
    logic                               accept;
    tolr_pkg::clip_t                    dp;
    tolr_pkg::clip_t                    dm;

    assign s_ready  = !job_full;
    assign accept   = s_valid && !job_full;
    assign fill_eff = s_data.row_start ? 2'd0 : fill_reg;
    assign job_push = accept && (fill_eff == 2'd2);

    assign dp = tolr_pkg::clip_word(tolr_pkg::SUM_W'(s_data.sample_value)
                                    - tolr_pkg::SUM_W'(middle_reg));
    assign dm = tolr_pkg::clip_word(tolr_pkg::SUM_W'(middle_reg)
                                    - tolr_pkg::SUM_W'(older_reg));

    always_comb begin
        job_data.middle = middle_reg;
        job_data.dp     = dp.value;
        job_data.dm     = dm.value;
        job_data.dx     = width_reg;
        job_data.sat    = dp.hit || dm.hit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= 2'd0;
        end else if (accept) begin
            fill_reg <= (fill_eff == 2'd2) ? 2'd2 : fill_eff + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            older_reg  <= middle_reg;
            middle_reg <= s_data.sample_value;
            width_reg  <= s_data.cell_width;
        end
    end

endmodule

[rtl/tolr_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tolr_back
// Limiter sequencer: squares, band test, blend weight by restoring
// division, face offsets with a byte-serial divide by three, positivity
// guard and the result register.
// ----------------------------------------------------------------------------
module tolr_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                positivity_enable,
    input  tolr_pkg::job_t      job_data,
    input  logic                job_valid,
    output logic                job_pop,
    output tolr_pkg::out_item_t m_data,
    output logic                m_valid,
    input  logic                m_ready
);

    tolr_pkg::back_state_t state_reg;
    tolr_pkg::back_state_t state_next;
    tolr_pkg::job_t        job_reg;
    tolr_pkg::band_t       band_reg;
    tolr_pkg::out_item_t   out_reg;

    logic [tolr_pkg::SQ_W-1:0]   sqp_reg;
    logic [tolr_pkg::SQ_W-1:0]   sqm_reg;
    logic [tolr_pkg::SQ_W-1:0]   d_reg;
    logic                        small_reg;
    logic [63:0]                 h_reg;
    logic                        forced_reg;
    tolr_pkg::lim_t              limp_reg;
    tolr_pkg::lim_t              limm_reg;
    logic                        below_reg;
    logic                        hle_reg;
    logic                        hge_reg;
    logic [50:0]                 prod_reg;
    logic                        nbig_reg;
    logic [63:0]                 num_reg;
    logic [tolr_pkg::BLEND_BITS-1:0] w_reg;
    logic [tolr_pkg::CNT_W-1:0]  cnt_reg;
    logic signed [57:0]          mixp_reg;
    logic signed [57:0]          mixm_reg;
    logic [tolr_pkg::DIV_W-1:0]  up_reg;
    logic [tolr_pkg::DIV_W-1:0]  um_reg;
    logic [1:0]                  remp_reg;
    logic [1:0]                  remm_reg;
    logic                        negqp_reg;
    logic                        negqm_reg;
    logic signed [tolr_pkg::WORD_W-1:0] vp_reg;
    logic signed [tolr_pkg::WORD_W-1:0] vm_reg;
    logic                        sat_reg;

    // combinational helpers
    logic [tolr_pkg::WORD_W-1:0] ap;
    logic [tolr_pkg::WORD_W-1:0] am;
    logic [62:0]                 s_sum;
    logic [63:0]                 s_wide;
    logic [63:0]                 d_wide;
    logic [63:0]                 n_abs;
    logic [63:0]                 n_scaled;
    logic                        outside;
    tolr_pkg::band_t             band_pick;
    logic [63:0]                 num_dbl;
    logic                        take;
    logic signed [16:0]          wq;
    logic signed [40:0]          dfp;
    logic signed [40:0]          dfm;
    logic signed [40:0]          lp;
    logic signed [40:0]          lm;
    logic signed [40:0]          bp;
    logic signed [40:0]          bm;
    logic [9:0]                  stepp;
    logic [9:0]                  stepm;
    logic signed [40:0]          offp;
    logic signed [40:0]          offm;
    tolr_pkg::clip_t             facep;
    tolr_pkg::clip_t             facem;
    logic signed [tolr_pkg::WORD_W-1:0] mm;
    logic signed [32:0]          half;
    tolr_pkg::clip_t             fbp;
    tolr_pkg::clip_t             fbm;
    logic                        use_fb;

    function automatic tolr_pkg::lim_t limiter(input logic signed [31:0] x,
                                               input logic signed [31:0] y);
        tolr_pkg::lim_t r;
        logic signed [tolr_pkg::LIM_W-1:0] xe;
        logic signed [tolr_pkg::LIM_W-1:0] ye;
        logic signed [tolr_pkg::LIM_W-1:0] bx;
        logic signed [tolr_pkg::LIM_W-1:0] by;
        logic signed [tolr_pkg::LIM_W-1:0] t;
        logic signed [tolr_pkg::LIM_W-1:0] u;
        xe     = tolr_pkg::LIM_W'(x);
        ye     = tolr_pkg::LIM_W'(y);
        r.neg  = x[31];
        r.zero = (x == '0);
        bx     = r.neg ? -xe : xe;
        by     = r.neg ? -ye : ye;
        r.q6   = (bx <<< 2) + (by <<< 1);
        t      = (bx <<< 3) + bx;
        u      = (by <<< 3) + (by <<< 2);
        if (u < t) t = u;
        if (r.q6 < t) t = r.q6;
        u      = -((by <<< 1) + by);
        if (u > t) t = u;
        if (r.q6 < t) t = r.q6;
        r.psi6 = (t < 0) ? '0 : t;
        return r;
    endfunction

    // face term 12*d*lim for one face, plus 12 and floored by 8 ahead of the divide by three
    function automatic logic signed [40:0] face12(input tolr_pkg::lim_t l,
                                                  input tolr_pkg::band_t b,
                                                  input logic signed [57:0] mix);
        logic signed [40:0] v;
        unique case (b)
            tolr_pkg::BAND_Q:     v = 41'(l.q6) <<< 1;
            tolr_pkg::BAND_PSI:   v = 41'(l.psi6) <<< 1;
            tolr_pkg::BAND_BLEND: v = 41'(l.q6) + 41'(l.psi6) + 41'(mix >>> tolr_pkg::BLEND_BITS);
            default:              v = '0;
        endcase
        if (l.zero) begin
            v = '0;
        end else if (l.neg) begin
            v = -v;
        end
        // floor((v + 12) / 8); the divide by three follows
        return (v + 41'sd12) >>> 3;
    endfunction

    function automatic logic [9:0] div3_byte(input logic [1:0] rem, input logic [7:0] din);
        logic [2:0] r;
        logic [7:0] q;
        r = {1'b0, rem};
        for (int i = 7; i >= 0; i--) begin
            r = {r[1:0], din[i]};
            if (r >= 3'd3) begin
                r    = r - 3'd3;
                q[i] = 1'b1;
            end else begin
                q[i] = 1'b0;
            end
        end
        return {r[1:0], q};
    endfunction

    assign ap = job_reg.dp[31] ? 32'(-job_reg.dp) : 32'(job_reg.dp);
    assign am = job_reg.dm[31] ? 32'(-job_reg.dm) : 32'(job_reg.dm);

    assign s_sum    = 63'(sqp_reg) + 63'(sqm_reg);
    assign s_wide   = 64'(s_sum);
    assign d_wide   = 64'(d_reg);
    assign n_abs    = (h_reg >= d_wide) ? h_reg - d_wide : d_wide - h_reg;
    assign n_scaled = 64'({prod_reg, {tolr_pkg::EPS_SHIFT{1'b0}}});
    assign outside  = nbig_reg || (n_scaled >= d_wide);

    always_comb begin
        if (forced_reg) begin
            band_pick = tolr_pkg::BAND_PSI;
        end else if (hle_reg && outside) begin
            band_pick = tolr_pkg::BAND_Q;
        end else if (hge_reg && outside) begin
            band_pick = tolr_pkg::BAND_PSI;
        end else begin
            band_pick = tolr_pkg::BAND_BLEND;
        end
    end

    assign num_dbl = num_reg << 1;
    assign take    = (num_dbl >= d_wide);

    assign wq  = below_reg ? -$signed({1'b0, w_reg}) : $signed({1'b0, w_reg});
    assign dfp = 41'(limp_reg.psi6) - 41'(limp_reg.q6);
    assign dfm = 41'(limm_reg.psi6) - 41'(limm_reg.q6);

    assign lp = face12(limp_reg, band_reg, mixp_reg);
    assign lm = face12(limm_reg, band_reg, mixm_reg);
    // floor(b/3) for negative b is -floor((2-b)/3)
    assign bp = lp[40] ? 41'sd2 - lp : lp;
    assign bm = lm[40] ? 41'sd2 - lm : lm;

    assign stepp = div3_byte(remp_reg, up_reg[tolr_pkg::DIV_W-1 -: 8]);
    assign stepm = div3_byte(remm_reg, um_reg[tolr_pkg::DIV_W-1 -: 8]);

    assign offp  = negqp_reg ? -$signed({1'b0, up_reg}) : $signed({1'b0, up_reg});
    assign offm  = negqm_reg ? -$signed({1'b0, um_reg}) : $signed({1'b0, um_reg});
    assign facep = tolr_pkg::clip_word(tolr_pkg::SUM_W'(job_reg.middle) + tolr_pkg::SUM_W'(offp));
    assign facem = tolr_pkg::clip_word(tolr_pkg::SUM_W'(job_reg.middle) - tolr_pkg::SUM_W'(offm));

    always_comb begin
        if (job_reg.dp > 0 && job_reg.dm > 0) begin
            mm = (job_reg.dp < job_reg.dm) ? job_reg.dp : job_reg.dm;
        end else if (job_reg.dp < 0 && job_reg.dm < 0) begin
            mm = (job_reg.dp > job_reg.dm) ? job_reg.dp : job_reg.dm;
        end else begin
            mm = '0;
        end
    end

    assign half   = (33'(mm) + 33'sd1) >>> 1;
    assign fbp    = tolr_pkg::clip_word(tolr_pkg::SUM_W'(job_reg.middle) + tolr_pkg::SUM_W'(half));
    assign fbm    = tolr_pkg::clip_word(tolr_pkg::SUM_W'(job_reg.middle) - tolr_pkg::SUM_W'(half));
    assign use_fb = positivity_enable && (vp_reg < 0 || vm_reg < 0);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tolr_pkg::ST_IDLE:   if (job_valid) state_next = tolr_pkg::ST_SQUARE;
            tolr_pkg::ST_SQUARE: state_next = tolr_pkg::ST_SCALE;
            tolr_pkg::ST_SCALE:  state_next = tolr_pkg::ST_BAND;
            tolr_pkg::ST_BAND:   state_next = tolr_pkg::ST_CLASS;
            tolr_pkg::ST_CLASS: begin
                state_next = (band_pick == tolr_pkg::BAND_BLEND) ? tolr_pkg::ST_BLEND
                                                                 : tolr_pkg::ST_MIX;
            end
            tolr_pkg::ST_BLEND: begin
                if (cnt_reg == tolr_pkg::BLEND_LAST) state_next = tolr_pkg::ST_MIX;
            end
            tolr_pkg::ST_MIX:    state_next = tolr_pkg::ST_L12;
            tolr_pkg::ST_L12:    state_next = tolr_pkg::ST_DIV3;
            tolr_pkg::ST_DIV3: begin
                if (cnt_reg == tolr_pkg::DIV_LAST) state_next = tolr_pkg::ST_FACE;
            end
            tolr_pkg::ST_FACE:   state_next = tolr_pkg::ST_GUARD;
            tolr_pkg::ST_GUARD:  state_next = tolr_pkg::ST_OUT;
            tolr_pkg::ST_OUT:    if (m_ready) state_next = tolr_pkg::ST_IDLE;
            default:             state_next = tolr_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        job_pop = (state_reg == tolr_pkg::ST_IDLE) && job_valid;
        m_valid = (state_reg == tolr_pkg::ST_OUT);
        m_data  = out_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tolr_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == tolr_pkg::ST_BLEND || state_reg == tolr_pkg::ST_DIV3) begin
                cnt_reg <= (state_next == state_reg) ? cnt_reg + 1'b1 : '0;
            end else begin
                cnt_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            tolr_pkg::ST_IDLE: begin
                if (job_valid) job_reg <= job_data;
            end
            tolr_pkg::ST_SQUARE: begin
                small_reg <= !ap[31] && !am[31];
                sqp_reg   <= tolr_pkg::SQ_W'(ap[30:0]) * tolr_pkg::SQ_W'(ap[30:0]);
                sqm_reg   <= tolr_pkg::SQ_W'(am[30:0]) * tolr_pkg::SQ_W'(am[30:0]);
                d_reg     <= tolr_pkg::SQ_W'(job_reg.dx) * tolr_pkg::SQ_W'(job_reg.dx);
            end
            tolr_pkg::ST_SCALE: begin
                forced_reg <= !small_reg || (s_wide > tolr_pkg::S_LIMIT);
                h_reg      <= (s_wide << 6) + (s_wide << 5) + (s_wide << 2);
                limp_reg   <= limiter(job_reg.dp, job_reg.dm);
                limm_reg   <= limiter(job_reg.dm, job_reg.dp);
            end
            tolr_pkg::ST_BAND: begin
                below_reg <= (h_reg < d_wide);
                hle_reg   <= (h_reg <= d_wide);
                hge_reg   <= (h_reg >= d_wide);
                nbig_reg  <= |n_abs[63:23];
                prod_reg  <= 51'(n_abs[22:0]) * 51'(tolr_pkg::EPS_ODD);
            end
            tolr_pkg::ST_CLASS: begin
                band_reg <= band_pick;
                num_reg  <= n_scaled;
                w_reg    <= '0;
            end
            tolr_pkg::ST_BLEND: begin
                num_reg <= take ? num_dbl - d_wide : num_dbl;
                w_reg   <= {w_reg[tolr_pkg::BLEND_BITS-2:0], take};
            end
            tolr_pkg::ST_MIX: begin
                mixp_reg <= 58'(wq) * 58'(dfp);
                mixm_reg <= 58'(wq) * 58'(dfm);
            end
            tolr_pkg::ST_L12: begin
                up_reg    <= tolr_pkg::DIV_W'(bp);
                um_reg    <= tolr_pkg::DIV_W'(bm);
                negqp_reg <= lp[40];
                negqm_reg <= lm[40];
                remp_reg  <= 2'd0;
                remm_reg  <= 2'd0;
            end
            tolr_pkg::ST_DIV3: begin
                // one byte of each dividend per cycle, quotient shifts in behind
                up_reg   <= {up_reg[tolr_pkg::DIV_W-9:0], stepp[7:0]};
                um_reg   <= {um_reg[tolr_pkg::DIV_W-9:0], stepm[7:0]};
                remp_reg <= stepp[9:8];
                remm_reg <= stepm[9:8];
            end
            tolr_pkg::ST_FACE: begin
                vp_reg  <= facep.value;
                vm_reg  <= facem.value;
                sat_reg <= job_reg.sat || facep.hit || facem.hit;
            end
            tolr_pkg::ST_GUARD: begin
                out_reg.right_face_value <= use_fb ? fbp.value : vp_reg;
                out_reg.left_face_value  <= use_fb ? fbm.value : vm_reg;
                out_reg.fallback_used    <= use_fb;
                out_reg.saturated        <= sat_reg || (use_fb && (fbp.hit || fbm.hit));
            end
            tolr_pkg::ST_OUT: begin
                out_reg <= out_reg;
            end
            default: begin
                job_reg <= job_reg;
            end
        endcase
    end

    a_pop_starts_job: assert property (@(posedge aclk) disable iff (!aresetn)
        job_pop |=> state_reg == tolr_pkg::ST_SQUARE)
        else $error("job taken from queue but sequencer did not start");

    a_blend_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tolr_pkg::ST_BLEND && cnt_reg == tolr_pkg::BLEND_LAST)
        |=> state_reg == tolr_pkg::ST_MIX)
        else $error("blend weight division ran past its last bit");

    a_fallback_enabled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.fallback_used) |-> positivity_enable)
        else $error("minmod fallback reported while positivity guard is off");

endmodule

[sim/third_order_limited_reconstruction_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// third_order_limited_reconstruction_tb
// Streams rows of cells through the reconstruction block, predicts each
// face pair in fixed point alongside it and checks every result item.
// ----------------------------------------------------------------------------
module third_order_limited_reconstruction_tb;

    localparam longint TOP_VAL   = 64'sd2147483647;
    localparam longint BOT_VAL   = -64'sd2147483648;
    localparam longint EPS_INV   = 64'sd1000000000000;
    localparam int     MAX_CYCLE = 2000000;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    tolr_pkg::in_item_t  s_data;
    logic                m_valid;
    logic                m_ready;
    tolr_pkg::out_item_t m_data;
    logic                cfg_we;
    logic                cfg_wdata;

    // predictor state
    logic                pos_en;
    longint              prev_val;
    longint              mid_val;
    longint              mid_w;
    int                  held;
    tolr_pkg::out_item_t faces_due[$];
    int                  fail_count;
    int                  cycle_count;
    bit                  hold_off;
    int                  hold_cycles;
    int                  rx_count;
    int                  rx_seen;
    int                  rx_wait;

    third_order_limited_reconstruction u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always #5 aclk = ~aclk;

    function automatic longint sat_word(input longint x, inout bit hit);
        if (x > TOP_VAL) begin
            hit = 1;
            return TOP_VAL;
        end
        if (x < BOT_VAL) begin
            hit = 1;
            return BOT_VAL;
        end
        return x;
    endfunction

    function automatic longint div_floor(input longint a, input longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0) q--;
        return q;
    endfunction

    function automatic longint lmin(input longint a, input longint b);
        return a < b ? a : b;
    endfunction

    function automatic longint lmax(input longint a, input longint b);
        return a > b ? a : b;
    endfunction

    // twelve times x times the limiter
    function automatic longint scaled_offset(input longint x, input longint y,
                                             input tolr_pkg::band_t band,
                                             input longint wq);
        longint ax, ay, q6, t, psi6, l12;
        if (x == 0) return 0;
        ax = x < 0 ? -x : x;
        ay = x < 0 ? -y : y;
        q6 = 4 * ax + 2 * ay;
        t = lmin(9 * ax, 12 * ay);
        t = lmin(q6, t);
        t = lmax(-3 * ay, t);
        t = lmin(q6, t);
        psi6 = lmax(0, t);
        case (band)
            tolr_pkg::BAND_Q:   l12 = 2 * q6;
            tolr_pkg::BAND_PSI: l12 = 2 * psi6;
            default:            l12 = q6 + psi6
                                      + div_floor(wq * (psi6 - q6),
                                                  64'sd1 << tolr_pkg::BLEND_BITS);
        endcase
        return x < 0 ? -l12 : l12;
    endfunction

    function automatic longint min_mod(input longint a, input longint b);
        if (a > 0 && b > 0) return lmin(a, b);
        if (a < 0 && b < 0) return lmax(a, b);
        return 0;
    endfunction

    // advance the window by one item; once it is full, predict the middle cell's faces
    task automatic predict_faces(input tolr_pkg::in_item_t it);
        longint              smp, dp, dm, vp, vm, wq, half;
        logic [63:0]         ap, am, dsq, ssum, hsum, thr, gap, num, w;
        tolr_pkg::band_t     band;
        bit                  hit;
        tolr_pkg::out_item_t r;
        smp = longint'(it.sample_value);
        hit = 0;
        if (it.row_start) held = 0;
        if (held >= 2) begin
            dp = sat_word(smp - mid_val, hit);
            dm = sat_word(mid_val - prev_val, hit);
            ap = dp < 0 ? -dp : dp;
            am = dm < 0 ? -dm : dm;
            dsq = mid_w * mid_w;
            band = tolr_pkg::BAND_PSI;
            wq = 0;
            if (ap < (64'd1 << 31) && am < (64'd1 << 31)) begin
                ssum = ap * ap + am * am;
                if (ssum <= 64'hFFFF_FFFF_FFFF_FFFF / 100) begin
                    hsum = ssum * 100;
                    thr = (dsq + (EPS_INV - 1)) / EPS_INV;
                    if (hsum <= dsq && dsq - hsum >= thr) begin
                        band = tolr_pkg::BAND_Q;
                    end else if (hsum >= dsq && hsum - dsq >= thr) begin
                        band = tolr_pkg::BAND_PSI;
                    end else begin
                        gap = hsum < dsq ? dsq - hsum : hsum - dsq;
                        num = gap * EPS_INV;
                        w = 0;
                        for (int k = 0; k < tolr_pkg::BLEND_BITS; k++) begin
                            num = num << 1;
                            w = w << 1;
                            if (num >= dsq) begin
                                num = num - dsq;
                                w[0] = 1'b1;
                            end
                        end
                        band = tolr_pkg::BAND_BLEND;
                        wq = hsum < dsq ? -longint'(w) : longint'(w);
                    end
                end
            end
            vp = sat_word(mid_val + div_floor(scaled_offset(dp, dm, band, wq) + 12, 24), hit);
            vm = sat_word(mid_val - div_floor(scaled_offset(dm, dp, band, wq) + 12, 24), hit);
            r.fallback_used = 0;
            if (pos_en && (vp < 0 || vm < 0)) begin
                half = div_floor(min_mod(dp, dm) + 1, 2);
                vp = sat_word(mid_val + half, hit);
                vm = sat_word(mid_val - half, hit);
                r.fallback_used = 1;
            end
            r.right_face_value = vp[31:0];
            r.left_face_value  = vm[31:0];
            r.saturated        = hit;
            faces_due.push_back(r);
        end
        prev_val = mid_val;
        mid_val  = smp;
        mid_w    = longint'(it.cell_width);
        if (held < 2) held++;
    endtask

    // valid stays high between items sent with no gap; a random gap lowers it first
    task automatic send_item(input logic signed [31:0] v, input logic [30:0] w,
                             input logic rs, input bit gaps = 1);
        int gap;
        gap = gaps ? ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16)) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data  <= '{sample_value: v, cell_width: w, row_start: rs};
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        predict_faces(s_data);
        @(negedge aclk);
    endtask

    task automatic drain_and_wait();
        s_valid <= 1'b0;
        while (faces_due.size() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    task automatic write_positivity(input logic en);
        drain_and_wait();
        cfg_we    <= 1'b1;
        cfg_wdata <= en;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        pos_en = en;
    endtask

    function automatic logic [30:0] rand_width();
        case ($urandom_range(0, 5))
            0:       return 31'd1;
            1:       return 31'h7FFF_FFFF;
            2:       return 31'($urandom_range(1, 2000));
            default: return 31'($urandom_range(1, 31'h7FFF_FFFF));
        endcase
    endfunction

    function automatic logic [31:0] rand_value(input logic [31:0] near);
        case ($urandom_range(0, 5))
            0:       return $urandom();
            1:       return near + 32'($urandom_range(0, 400)) - 32'd200;
            2:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return near + 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
        endcase
    endfunction

    task automatic test_extremes();
        send_item(32'sh0001_0000, 31'h0001_0000, 1'b1);
        send_item(32'sh7FFF_FFFF, 31'h7FFF_FFFF, 1'b0);
        send_item(-32'sh8000_0000, 31'd1, 1'b0);
        send_item(32'sh7FFF_FFFF, 31'd1, 1'b0);
        send_item(32'sh0, 31'h0000_8000, 1'b0);
        // flat row: both differences zero
        send_item(32'sh0002_0000, 31'h0001_0000, 1'b1);
        send_item(32'sh0002_0000, 31'h0001_0000, 1'b0);
        send_item(32'sh0002_0000, 31'h0001_0000, 1'b0);
        // row restart after one item gives no result
        send_item(32'sh0003_0000, 31'h0001_0000, 1'b1);
        send_item(32'sh0004_0000, 31'h0001_0000, 1'b1);
        // blend band: eta close to one
        send_item(32'sh0, 31'd1000, 1'b1);
        send_item(32'sd100, 31'd1000, 1'b0);
        send_item(32'sd100, 31'd1000, 1'b0);
        // a sharp drop and an extremum
        send_item(-32'sh0001_0000, 31'd3, 1'b0);
        send_item(32'sh0005_0000, 31'd3, 1'b0);
    endtask

    task automatic test_positivity();
        write_positivity(1'b1);
        send_item(32'sd10, 31'd1, 1'b1);
        send_item(32'sd2, 31'd1, 1'b0);
        send_item(32'sd500, 31'd1, 1'b0);
        send_item(-32'sd40, 31'd1, 1'b0);
        send_item(-32'sh8000_0000, 31'd1, 1'b0);
        send_item(32'sh7FFF_FFFF, 31'h7FFF_FFFF, 1'b0);
    endtask

    task automatic test_random_rows(input int n);
        logic [31:0] v;
        v = $urandom();
        for (int i = 0; i < n; i++) begin
            v = rand_value(v);
            send_item(v, rand_width(), ($urandom_range(0, 19) == 0));
        end
    endtask

    // receiver stalls while the sender keeps offering items
    task automatic test_backpressure();
        hold_cycles = 300;
        hold_off    = 1;
        for (int i = 0; i < 12; i++)
            send_item($urandom(), rand_width(), (i == 0), 0);
        drain_and_wait();
        wait (!hold_off);
    endtask

    // result side: a fresh wait per item, and a long hold-off on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_off) begin
            m_ready <= 1'b0;
            if (hold_cycles > 0) hold_cycles--;
            else hold_off = 0;
        end else begin
            if (rx_seen != rx_count) begin
                rx_seen = rx_count;
                rx_wait = $urandom_range(0, 16);
            end
            if (rx_wait > 0) begin
                m_ready <= 1'b0;
                rx_wait--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        tolr_pkg::out_item_t e;
        cycle_count++;
        if (aresetn && m_valid && m_ready) begin
            rx_count++;
            if (faces_due.size() == 0) begin
                $error("result item with nothing expected");
                fail_count++;
            end else begin
                e = faces_due.pop_front();
                if (m_data.right_face_value !== e.right_face_value) begin
                    $error("right_face_value expected %0d got %0d",
                           e.right_face_value, m_data.right_face_value);
                    fail_count++;
                end
                if (m_data.left_face_value !== e.left_face_value) begin
                    $error("left_face_value expected %0d got %0d",
                           e.left_face_value, m_data.left_face_value);
                    fail_count++;
                end
                if (m_data.fallback_used !== e.fallback_used) begin
                    $error("fallback_used expected %0b got %0b",
                           e.fallback_used, m_data.fallback_used);
                    fail_count++;
                end
                if (m_data.saturated !== e.saturated) begin
                    $error("saturated expected %0b got %0b", e.saturated, m_data.saturated);
                    fail_count++;
                end
            end
        end
        if (cycle_count > MAX_CYCLE) begin
            $display("third_order_limited_reconstruction test failed");
            $finish;
        end
    end

    initial begin
        aclk        = 0;
        aresetn     = 0;
        s_valid     = 0;
        s_data      = '0;
        cfg_we      = 0;
        cfg_wdata   = 0;
        m_ready     = 0;
        pos_en      = 0;
        prev_val    = 0;
        mid_val     = 0;
        mid_w       = 0;
        held        = 0;
        fail_count  = 0;
        cycle_count = 0;
        hold_off    = 0;
        hold_cycles = 0;
        rx_count    = 0;
        rx_seen     = 0;
        rx_wait     = 0;
        repeat (2) @(negedge aclk);
        aresetn = 1;

        test_extremes();
        test_positivity();
        test_random_rows(200);
        test_backpressure();
        write_positivity(1'b0);
        test_random_rows(180);

        drain_and_wait();
        if (fail_count == 0 && faces_due.size() == 0) begin
            $display("third_order_limited_reconstruction test passed");
        end else begin
            $display("third_order_limited_reconstruction test failed");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/tolr_pkg.sv
rtl/tolr_fifo.sv
rtl/tolr_front.sv
rtl/tolr_back.sv
rtl/third_order_limited_reconstruction.sv
sim/third_order_limited_reconstruction_tb.sv
